@@ hdl/ax25p_pkg.sv @@
`default_nettype none

package ax25p_pkg;

  localparam int MAX_REPEATERS = 8;
  localparam int CALL_CHARS    = 6;
  localparam int LENGTH_BITS   = 12;

  localparam int CHAR_W   = 7;
  localparam int CALL_W   = CHAR_W * CALL_CHARS;
  localparam int RPT_W    = 4;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = LENGTH_BITS + 1;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0]        CTRL_UI     = 8'h03;
  localparam logic [7:0]        PID_NONE    = 8'hF0;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 7'h20;
  localparam logic [CNT_W-1:0]  FCS_BYTES   = CNT_W'(2);
  localparam logic [CNT_W-1:0]  INFO_CAP    = CNT_W'((1 << LENGTH_BITS) + 1);

  typedef enum logic [2:0] {
    PH_DST  = 3'd0,
    PH_SRC  = 3'd1,
    PH_RPT  = 3'd2,
    PH_CTRL = 3'd3,
    PH_PID  = 3'd4,
    PH_INFO = 3'd5,
    PH_SKIP = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DST      = 3'd0,
    KIND_SRC      = 3'd1,
    KIND_RPT      = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_BAD_CTRL = 3'd4,
    KIND_BAD_PID  = 3'd5,
    KIND_TRUNC    = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [CALL_W-1:0]      callsign;
    logic [3:0]             ssid;
    logic                   repeated;
    logic [IDX_W-1:0]       rpt_index;
    logic [7:0]             control;
    logic [7:0]             pid;
    logic [LENGTH_BITS-1:0] info_len;
    logic                   last;
  } rec_t;

  typedef struct packed {
    logic v0;
    logic v1;
    rec_t r0;
    rec_t r1;
  } push_t;

  localparam rec_t REC_ZERO = '{
    kind:      KIND_DST,
    callsign:  '0,
    ssid:      '0,
    repeated:  1'b0,
    rpt_index: '0,
    control:   '0,
    pid:       '0,
    info_len:  '0,
    last:      1'b0
  };

endpackage

`default_nettype wire

@@ hdl/ax25_ui_header_parser_unit.sv @@
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    frame_byte, end_of_frame
// out      output     out_valid / out_stall  record_kind .. last_of_frame
//
// One frame byte is taken per cycle while in_stall is low; the front decodes
// it in that cycle and queues zero, one or two records. The back drains one
// record per cycle into the output register while out_stall is low.
// Reset (rst, synchronous) empties the queue and restarts header decoding.
// in_stall rises while the queue holds fewer than two free slots; out_stall
// holds the output register and, through the queue, the front.
`default_nettype none

module ax25_ui_header_parser_unit
  import ax25p_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             frame_byte,
  input  wire logic                   end_of_frame,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [2:0]                  record_kind,
  output logic [CALL_W-1:0]           callsign,
  output logic [3:0]                  ssid,
  output logic                        repeated,
  output logic [IDX_W-1:0]            repeater_index,
  output logic [7:0]                  control_byte,
  output logic [7:0]                  pid_byte,
  output logic [LENGTH_BITS-1:0]      info_length,
  output logic                        last_of_frame
);

  push_t push;
  rec_t  head;
  rec_t  out_rec;
  logic  not_empty;
  logic  room_two;
  logic  pop;
  logic  accept;

  // Take a byte only when the queue can absorb the worst case of two records.
  assign in_stall = !room_two;
  assign accept   = in_valid && room_two;

  ax25p_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_byte   (frame_byte),
    .end_of_frame (end_of_frame),
    .push         (push)
  );

  ax25p_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room_two  (room_two)
  );

  ax25p_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rec   (out_rec)
  );

  // Split the held record onto the result ports.
  assign record_kind    = out_rec.kind;
  assign callsign       = out_rec.callsign;
  assign ssid           = out_rec.ssid;
  assign repeated       = out_rec.repeated;
  assign repeater_index = out_rec.rpt_index;
  assign control_byte   = out_rec.control;
  assign pid_byte       = out_rec.pid;
  assign info_length    = out_rec.info_len;
  assign last_of_frame  = out_rec.last;

endmodule

`default_nettype wire

@@ hdl/ax25p_front.sv @@
`default_nettype none

module ax25p_front
  import ax25p_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] frame_byte,
  input  wire logic       end_of_frame,
  output push_t           push
);

  phase_t            phase, phase_adv, phase_next;
  logic [2:0]        byte_in_address, byte_in_address_adv, byte_in_address_next;
  logic [CALL_W-1:0] callsign_shift, callsign_shift_adv, callsign_shift_next;
  logic [RPT_W-1:0]  repeater_count, repeater_count_adv, repeater_count_next;
  logic [7:0]        held_control, held_control_adv, held_control_next;
  logic [7:0]        held_pid, held_pid_adv, held_pid_next;
  logic [CNT_W-1:0]  info_counter, info_counter_adv, info_counter_next;

  logic              in_address;
  logic              addr_done;
  logic [CHAR_W-1:0] char_dec;
  logic [RPT_W-1:0]  repeater_count_inc;

  assign in_address = (phase == PH_DST) || (phase == PH_SRC) || (phase == PH_RPT);
  assign addr_done  = in_address && (byte_in_address >= 3'(CALL_CHARS));
  assign char_dec   = (frame_byte[7:1] == CHAR_SPACE) ? '0 : frame_byte[7:1];
  assign repeater_count_inc = repeater_count + RPT_W'(1);

  // Advance state for one byte, before the end-of-frame restart.
  always_comb begin
    phase_adv           = phase;
    byte_in_address_adv = byte_in_address;
    callsign_shift_adv  = callsign_shift;
    repeater_count_adv  = repeater_count;
    held_control_adv    = held_control;
    held_pid_adv        = held_pid;
    info_counter_adv    = info_counter;
    unique case (phase)
      PH_DST, PH_SRC, PH_RPT: begin
        if (!addr_done) begin
          callsign_shift_adv  = {callsign_shift[CALL_W-CHAR_W-1:0], char_dec};
          byte_in_address_adv = byte_in_address + 3'd1;
        end else begin
          byte_in_address_adv = '0;
          callsign_shift_adv  = '0;
          if (phase == PH_DST) begin
            phase_adv = PH_SRC;
          end else if (phase == PH_SRC) begin
            phase_adv = frame_byte[0] ? PH_CTRL : PH_RPT;
          end else begin
            repeater_count_adv = repeater_count_inc;
            if (frame_byte[0] || (repeater_count_inc >= RPT_W'(MAX_REPEATERS))) begin
              phase_adv = PH_CTRL;
            end
          end
        end
      end
      PH_CTRL: begin
        held_control_adv = frame_byte;
        phase_adv        = (frame_byte != CTRL_UI) ? PH_SKIP : PH_PID;
      end
      PH_PID: begin
        held_pid_adv = frame_byte;
        if (frame_byte != PID_NONE) begin
          phase_adv = PH_SKIP;
        end else begin
          phase_adv        = PH_INFO;
          info_counter_adv = '0;
        end
      end
      PH_INFO: begin
        if (info_counter < INFO_CAP) begin
          info_counter_adv = info_counter + CNT_W'(1);
        end
      end
      PH_SKIP: ;
      default: ;
    endcase
  end

  // Restart every piece of state after the last byte of a frame.
  always_comb begin
    if (end_of_frame) begin
      phase_next           = PH_DST;
      byte_in_address_next = '0;
      callsign_shift_next  = '0;
      repeater_count_next  = '0;
      held_control_next    = '0;
      held_pid_next        = '0;
      info_counter_next    = '0;
    end else begin
      phase_next           = phase_adv;
      byte_in_address_next = byte_in_address_adv;
      callsign_shift_next  = callsign_shift_adv;
      repeater_count_next  = repeater_count_adv;
      held_control_next    = held_control_adv;
      held_pid_next        = held_pid_adv;
      info_counter_next    = info_counter_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DST;
      byte_in_address <= '0;
      callsign_shift  <= '0;
      repeater_count  <= '0;
      held_control    <= '0;
      held_pid        <= '0;
      info_counter    <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_in_address <= byte_in_address_next;
      callsign_shift  <= callsign_shift_next;
      repeater_count  <= repeater_count_next;
      held_control    <= held_control_next;
      held_pid        <= held_pid_next;
      info_counter    <= info_counter_next;
    end
  end

  // Records caused by this byte: an address or reject first, then the frame end.
  always_comb begin
    rec_t rec_a;
    rec_t rec_e;
    logic va;
    logic ve;
    rec_a = REC_ZERO;
    rec_e = REC_ZERO;
    va    = 1'b0;
    ve    = 1'b0;

    if (addr_done) begin
      va             = 1'b1;
      rec_a.callsign = callsign_shift;
      rec_a.ssid     = frame_byte[4:1];
      if (phase == PH_DST) begin
        rec_a.kind = KIND_DST;
      end else if (phase == PH_SRC) begin
        rec_a.kind = KIND_SRC;
      end else begin
        rec_a.kind      = KIND_RPT;
        rec_a.repeated  = frame_byte[7];
        rec_a.rpt_index = repeater_count[IDX_W-1:0];
      end
    end else if ((phase == PH_CTRL) && (frame_byte != CTRL_UI)) begin
      va            = 1'b1;
      rec_a.kind    = KIND_BAD_CTRL;
      rec_a.control = frame_byte;
      rec_a.last    = 1'b1;
    end else if ((phase == PH_PID) && (frame_byte != PID_NONE)) begin
      va            = 1'b1;
      rec_a.kind    = KIND_BAD_PID;
      rec_a.control = held_control;
      rec_a.pid     = frame_byte;
      rec_a.last    = 1'b1;
    end

    rec_e.control = held_control_adv;
    rec_e.pid     = held_pid_adv;
    rec_e.last    = 1'b1;
    rec_e.kind    = KIND_TRUNC;
    if (end_of_frame && (phase_adv != PH_SKIP)) begin
      ve = 1'b1;
      if ((phase_adv == PH_INFO) && (info_counter_adv >= FCS_BYTES)) begin
        rec_e.kind     = KIND_DONE;
        rec_e.info_len = LENGTH_BITS'(info_counter_adv - FCS_BYTES);
      end
    end

    push.v0 = accept && (va || ve);
    push.v1 = accept && va && ve;
    push.r0 = va ? rec_a : rec_e;
    push.r1 = rec_e;
  end

endmodule

`default_nettype wire

@@ hdl/ax25p_queue.sv @@
`default_nettype none

module ax25p_queue
  import ax25p_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire push_t push,
  input  wire logic pop,
  output rec_t      head,
  output logic      not_empty,
  output logic      room_two
);

  rec_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count, count_next;
  logic [Q_PTR_W-1:0] wr_ptr_alt;

  assign wr_ptr_alt = wr_ptr + Q_PTR_W'(1);
  assign head       = slots[rd_ptr];
  assign not_empty  = (count != '0);
  assign room_two   = (count <= Q_CNT_W'(Q_DEPTH - 2));
  assign count_next = count + Q_CNT_W'(push.v0) + Q_CNT_W'(push.v1) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push.v0) + Q_PTR_W'(push.v1);
      rd_ptr <= rd_ptr + Q_PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      slots[wr_ptr_alt] <= push.r1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ax25p_back.sv @@
`default_nettype none

module ax25p_back
  import ax25p_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire rec_t head,
  input  wire logic not_empty,
  output logic      pop,
  input  wire logic out_stall,
  output logic      out_valid,
  output rec_t      out_rec
);

  // Refill the output register when it is empty or its request is taken.
  assign pop = not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec <= head;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ax25p_checker.sv @@
`default_nettype none

module ax25p_checker
  import ax25p_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic [7:0]             frame_byte,
  input wire logic                   end_of_frame,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [2:0]             record_kind,
  input wire logic [CALL_W-1:0]      callsign,
  input wire logic [3:0]             ssid,
  input wire logic                   repeated,
  input wire logic [IDX_W-1:0]       repeater_index,
  input wire logic [7:0]             control_byte,
  input wire logic [7:0]             pid_byte,
  input wire logic [LENGTH_BITS-1:0] info_length,
  input wire logic                   last_of_frame
);

  logic is_addr;
  logic is_end;

  assign is_addr = (record_kind == KIND_DST) || (record_kind == KIND_SRC) ||
                   (record_kind == KIND_RPT);
  assign is_end  = (record_kind == KIND_DONE) || (record_kind == KIND_BAD_CTRL) ||
                   (record_kind == KIND_BAD_PID) || (record_kind == KIND_TRUNC);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(frame_byte) && $stable(end_of_frame))
    else $error("request changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(record_kind) && $stable(callsign)
      && $stable(info_length) && $stable(last_of_frame))
    else $error("result changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_end |-> last_of_frame && (callsign == '0) && (ssid == '0))
    else $error("frame end record malformed");

  a_addr_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_addr |-> !last_of_frame && (control_byte == '0) && (pid_byte == '0)
      && (info_length == '0))
    else $error("address record carries frame fields");

  a_rpt_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (record_kind != KIND_RPT) |-> !repeated && (repeater_index == '0))
    else $error("repeater fields on non-repeater record");

endmodule

bind ax25_ui_header_parser_unit ax25p_checker u_ax25p_checker (.*);

`default_nettype wire
